FILE: rtl/core/rgb2hsv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

    // Saturation is given with 8 fraction bits and may reach exactly 1.0.
    localparam int SAT_FRAC_BITS = 8;
    localparam int SAT_W         = SAT_FRAC_BITS + 1;
    localparam int SAT_ONE       = 2 ** SAT_FRAC_BITS;

    // Hue constants in whole degrees.
    localparam int DEG_SIXTY     = 60;
    localparam int DEG_FULL_TURN = 360;
    localparam int DEG_GREEN_OFS = 120;
    localparam int DEG_BLUE_OFS  = 240;

    // Which channel holds the maximum; ties go to red, then to green.
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    // Side flags that travel next to the divider pipeline.
    typedef struct packed {
        max_sel_t sel;
        logic     grey;
        logic     black;
    } pix_flags_t;

endpackage

FILE: rtl/core/rgb2hsv_front.sv
// ----------------------------------------------------------------------------
// rgb2hsv_front
// Two register stages: maximum and minimum search, then the numerators and
// divisors for the hue and saturation dividers.
// ----------------------------------------------------------------------------
module rgb2hsv_front #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6,
    parameter int NUM_W             = 22
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [CHANNEL_BITS-1:0]    red,
    input  logic [CHANNEL_BITS-1:0]    green,
    input  logic [CHANNEL_BITS-1:0]    blue,
    output logic [NUM_W-1:0]           hue_num,
    output logic [CHANNEL_BITS:0]      hue_den,
    output logic [NUM_W-1:0]           sat_num,
    output logic [CHANNEL_BITS:0]      sat_den,
    output logic [CHANNEL_BITS-1:0]    brightness,
    output rgb2hsv_pkg::pix_flags_t    flags
);
    import rgb2hsv_pkg::*;

    localparam int CB        = CHANNEL_BITS;
    // Twice 60 degrees in hue units: the numerator is doubled for rounding.
    localparam int HUE_SCALE = 2 * DEG_SIXTY * (2 ** HUE_FRACTION_BITS);

    // Stage 1: the largest channel, the smallest channel and the two others.
    logic [CB-1:0] max_next, min_next, pos_next, neg_next;
    max_sel_t      sel_next;
    logic [CB-1:0] max_reg, min_reg, pos_reg, neg_reg;
    max_sel_t      sel_reg;

    always_comb begin
        if (red >= green && red >= blue) begin
            sel_next = SEL_RED;
            max_next = red;
            pos_next = green;
            neg_next = blue;
        end else if (green >= blue) begin
            sel_next = SEL_GREEN;
            max_next = green;
            pos_next = blue;
            neg_next = red;
        end else begin
            sel_next = SEL_BLUE;
            max_next = blue;
            pos_next = red;
            neg_next = green;
        end
        if (red <= green && red <= blue) begin
            min_next = red;
        end else if (green <= blue) begin
            min_next = green;
        end else begin
            min_next = blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            max_reg <= max_next;
            min_reg <= min_next;
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            sel_reg <= sel_next;
        end
    end

    // Stage 2: the channel difference is shifted up by delta so that it is
    // never negative; the hue base offset later takes the shift back out.
    logic [CB-1:0]    delta;
    logic [CB:0]      shifted_diff;
    logic [NUM_W-1:0] hue_num_next, sat_num_next;
    pix_flags_t       flags_next;

    logic [NUM_W-1:0] hue_num_reg, sat_num_reg;
    logic [CB:0]      hue_den_reg, sat_den_reg;
    logic [CB-1:0]    bright_reg;
    pix_flags_t       flags_reg;

    always_comb begin
        delta        = max_reg - min_reg;
        shifted_diff = (CB+1)'(pos_reg) + (CB+1)'(delta) - (CB+1)'(neg_reg);
        hue_num_next = NUM_W'(shifted_diff) * NUM_W'(HUE_SCALE) + NUM_W'(delta);
        sat_num_next = (NUM_W'(delta) << (SAT_FRAC_BITS + 1)) + NUM_W'(max_reg);
        flags_next.sel   = sel_reg;
        flags_next.grey  = (delta == '0);
        flags_next.black = (max_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_num_reg <= hue_num_next;
            sat_num_reg <= sat_num_next;
            hue_den_reg <= {delta, 1'b0};
            sat_den_reg <= {max_reg, 1'b0};
            bright_reg  <= max_reg;
            flags_reg   <= flags_next;
        end
    end

    assign hue_num    = hue_num_reg;
    assign hue_den    = hue_den_reg;
    assign sat_num    = sat_num_reg;
    assign sat_den    = sat_den_reg;
    assign brightness = bright_reg;
    assign flags      = flags_reg;

endmodule

FILE: rtl/core/rgb2hsv_div.sv
// ----------------------------------------------------------------------------
// rgb2hsv_div
// Pipelined restoring divider that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgb2hsv_div #(
    parameter int DEN_W  = 9,
    parameter int QUOT_W = 13
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [DEN_W+QUOT_W-1:0]   num,
    input  logic [DEN_W-1:0]          den,
    output logic [QUOT_W-1:0]         quo
);
    localparam int NUM_W = DEN_W + QUOT_W;

    // The caller keeps num below den * 2^QUOT_W, so the quotient fits.
    logic [NUM_W-1:0]  rem_reg [QUOT_W-1];
    logic [DEN_W-1:0]  den_reg [QUOT_W-1];
    logic [QUOT_W-1:0] quo_reg [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;

        logic [NUM_W-1:0]  rem_in, trial, rem_next;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] quo_in, quo_next;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb begin
            trial    = NUM_W'(den_in) << BIT;
            quo_next = quo_in;
            if (rem_in >= trial) begin
                rem_next      = rem_in - trial;
                quo_next[BIT] = 1'b1;
            end else begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QUOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUOT_W-1];

endmodule

FILE: rtl/core/rgb2hsv_skid.sv
// ----------------------------------------------------------------------------
// rgb2hsv_skid
// Output register with a skid entry, so the ready toward the pipeline is
// taken from a flip-flop.
// ----------------------------------------------------------------------------
module rgb2hsv_skid #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              out_valid_reg, skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg, skid_data_reg;
    logic              load_out, load_skid;

    assign in_ready  = !skid_valid_reg;
    assign load_out  = out_ready || !out_valid_reg;
    assign load_skid = !load_out && in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (load_skid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (load_skid) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/rgb_to_hsv_pixel_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_core
// Converts RGB pixels to hue, saturation and value, one per clock when ready.
//
//   Channel   Direction  Payload (tdata, from bit 0 up)
//   s_        in         red, green, blue (CHANNEL_BITS each)
//   m_        out        hue (HUE_W), saturation (9), brightness (CHANNEL_BITS)
//
// One pixel is accepted per cycle while s_tready is high. A result passes
// through two front stages, the divider pipelines that retire one quotient
// bit per stage, the final stage and the output register. Reset clears only
// the valid bits. When the output is stalled and a further result arrives,
// the skid entry fills and s_tready, driven from its registered valid flag,
// drops; the whole pipeline then holds.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6,
    localparam int HUE_W  = $clog2(360 * (2 ** HUE_FRACTION_BITS)),
    localparam int S_TW   = ((3 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int M_TW   = ((HUE_W + 9 + CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [S_TW-1:0] s_tdata,   // red, green, blue
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [M_TW-1:0] m_tdata    // hue, saturation, brightness
);
    import rgb2hsv_pkg::*;

    localparam int CB       = CHANNEL_BITS;
    localparam int HUE_ONE  = 2 ** HUE_FRACTION_BITS;
    localparam int HUE_TURN = DEG_FULL_TURN * HUE_ONE;
    localparam int HUE_QW   = $clog2(2 * DEG_SIXTY * HUE_ONE + 1);
    localparam int QUOT_W   = (HUE_QW > SAT_W) ? HUE_QW : SAT_W;
    localparam int NUM_W    = CB + 1 + QUOT_W;
    localparam int SUM_W    = HUE_W + 1;
    localparam int STAGES   = 2 + QUOT_W + 1;
    localparam int PACK_W   = HUE_W + SAT_W + CB;
    // Hue bases per maximum channel, less the 60 degree shift of the front.
    localparam int BASE_RED   = (DEG_FULL_TURN - DEG_SIXTY) * HUE_ONE;
    localparam int BASE_GREEN = (DEG_GREEN_OFS - DEG_SIXTY) * HUE_ONE;
    localparam int BASE_BLUE  = (DEG_BLUE_OFS - DEG_SIXTY) * HUE_ONE;

    logic en;
    logic valid_reg [STAGES];

    // Front stages.
    logic [NUM_W-1:0] hue_num, sat_num;
    logic [CB:0]      hue_den, sat_den;
    logic [CB-1:0]    front_bright;
    pix_flags_t       front_flags;

    rgb2hsv_front #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .NUM_W             (NUM_W)
    ) u_front (
        .aclk       (aclk),
        .en         (en),
        .red        (s_tdata[CB-1:0]),
        .green      (s_tdata[2*CB-1:CB]),
        .blue       (s_tdata[3*CB-1:2*CB]),
        .hue_num    (hue_num),
        .hue_den    (hue_den),
        .sat_num    (sat_num),
        .sat_den    (sat_den),
        .brightness (front_bright),
        .flags      (front_flags)
    );

    // Dividers, run side by side with equal latency.
    logic [QUOT_W-1:0] hue_quo, sat_quo;

    rgb2hsv_div #(
        .DEN_W  (CB + 1),
        .QUOT_W (QUOT_W)
    ) u_hue_div (
        .aclk (aclk),
        .en   (en),
        .num  (hue_num),
        .den  (hue_den),
        .quo  (hue_quo)
    );

    rgb2hsv_div #(
        .DEN_W  (CB + 1),
        .QUOT_W (QUOT_W)
    ) u_sat_div (
        .aclk (aclk),
        .en   (en),
        .num  (sat_num),
        .den  (sat_den),
        .quo  (sat_quo)
    );

    // Brightness and flags ride along with the divider stages.
    logic [CB-1:0] bright_pipe_reg [QUOT_W];
    pix_flags_t    flags_pipe_reg  [QUOT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            bright_pipe_reg[0] <= front_bright;
            flags_pipe_reg[0]  <= front_flags;
            for (int i = 1; i < QUOT_W; i++) begin
                bright_pipe_reg[i] <= bright_pipe_reg[i-1];
                flags_pipe_reg[i]  <= flags_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < STAGES; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Final stage: add the hue base, wrap once, and apply the grey and
    // black special cases.
    pix_flags_t       post_flags;
    logic [SUM_W-1:0] hue_base, hue_sum;
    logic [HUE_W-1:0] hue_next, hue_reg;
    logic [SAT_W-1:0] sat_next, sat_reg;
    logic [CB-1:0]    bright_reg;

    assign post_flags = flags_pipe_reg[QUOT_W-1];

    always_comb begin
        case (post_flags.sel)
            SEL_RED:   hue_base = SUM_W'(BASE_RED);
            SEL_GREEN: hue_base = SUM_W'(BASE_GREEN);
            SEL_BLUE:  hue_base = SUM_W'(BASE_BLUE);
            default:   hue_base = '0;
        endcase
        hue_sum = SUM_W'(hue_quo) + hue_base;
        if (post_flags.grey) begin
            hue_next = '0;
        end else if (hue_sum >= SUM_W'(HUE_TURN)) begin
            hue_next = HUE_W'(hue_sum - SUM_W'(HUE_TURN));
        end else begin
            hue_next = HUE_W'(hue_sum);
        end
        sat_next = post_flags.black ? '0 : sat_quo[SAT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= bright_pipe_reg[QUOT_W-1];
        end
    end

    logic [PACK_W-1:0] out_data;

    rgb2hsv_skid #(
        .DATA_W (PACK_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_reg[STAGES-1]),
        .in_ready  (en),
        .in_data   ({bright_reg, sat_reg, hue_reg}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign s_tready = en;
    assign m_tdata  = M_TW'(out_data);

endmodule

FILE: rtl/core/rgb2hsv_checker.sv
// ----------------------------------------------------------------------------
// rgb2hsv_checker
// Port-level checks of the RGB to HSV pixel converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgb2hsv_checker #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6,
    localparam int HUE_W  = $clog2(360 * (2 ** HUE_FRACTION_BITS)),
    localparam int S_TW   = ((3 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int M_TW   = ((HUE_W + 9 + CHANNEL_BITS + 7) / 8) * 8
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic [S_TW-1:0] s_tdata,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [M_TW-1:0] m_tdata
);
    import rgb2hsv_pkg::*;

    localparam int HUE_TURN = DEG_FULL_TURN * (2 ** HUE_FRACTION_BITS);

    logic [HUE_W-1:0]        hue_f;
    logic [SAT_W-1:0]        sat_f;
    logic [CHANNEL_BITS-1:0] bright_f;

    assign hue_f    = m_tdata[HUE_W-1:0];
    assign sat_f    = m_tdata[HUE_W+SAT_W-1:HUE_W];
    assign bright_f = m_tdata[HUE_W+SAT_W+CHANNEL_BITS-1:HUE_W+SAT_W];

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side only backs off while a result is waiting downstream.
    a_ready_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending output transaction");

    a_ranges : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hue_f < HUE_W'(HUE_TURN)) && (sat_f <= SAT_W'(SAT_ONE)))
        else $error("hue or saturation out of range");

    a_black : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (bright_f == '0) |-> (hue_f == '0) && (sat_f == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel_core rgb2hsv_checker #(
    .CHANNEL_BITS      (CHANNEL_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_rgb2hsv_checker (.*);
